// File: hw/rtl/atfs_pkg.sv
// Shared constants and types for the animation timeline frame selector.
// No dependencies; imported by the selector top, frame_pick_checker and testbench.
package atfs_pkg;

  localparam int DEPTH     = 128;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int OP_W      = 2;
  localparam int FRAME_W   = 16;
  localparam int DUR_W     = 16;
  localparam int TICK_W    = 32;
  localparam int ECNT_W    = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;
  localparam int ACC_W     = DUR_W + IDX_W;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_DONE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TICKS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZE_MODE = 8'd3;

  localparam logic [FRAME_W-1:0] FRAME_NONE = 16'hffff;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [DUR_W-1:0]   dur;
  } entry_t;

endpackage

// File: hw/rtl/animation_timeline_frame_selector_top.sv
// Animation timeline frame selector: timeline memory, walk sequencer and result register.
// Depends on atfs_pkg.
// Load, upload-done and restart items, and ticks in freeze mode, pass from the sequencer's
// output state into the result register; other ticks first walk the timeline entries
// (1 to 128), one entry per cycle through the single memory read port, until one is hit.
// Throughput: one item at a time; the result register lets the next item start while a
// result waits. Synchronous active-low reset clears control state; the timeline is not cleared.
module animation_timeline_frame_selector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [atfs_pkg::OP_W-1:0]        in_operation,
  input  logic [atfs_pkg::IDX_W-1:0]       in_entry_index,
  input  logic [atfs_pkg::FRAME_W-1:0]     in_entry_frame,
  input  logic [atfs_pkg::DUR_W-1:0]       in_entry_duration,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [atfs_pkg::FRAME_W-1:0]     out_requested_frame,
  output logic                             out_upload_needed,
  output logic [atfs_pkg::FRAME_W-1:0]     out_shown_frame,
  output logic [atfs_pkg::TICK_W-1:0]      out_tick_position,
  input  logic                             cfg_wr_en,
  input  logic [atfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atfs_pkg::CFG_W-1:0]       cfg_wdata
);
  import atfs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [ECNT_W-1:0]  entry_count_r;
  logic [FRAME_W-1:0] frame_count_r;
  logic [TICK_W-1:0]  total_ticks_r;
  logic               freeze_r;

  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [FRAME_W-1:0] pending_r, pending_nxt;
  logic [FRAME_W-1:0] displayed_r, displayed_nxt;
  logic               dirty_r, dirty_nxt;

  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r, rd_vld_nxt;
  logic [ACC_W-1:0]   at_r, at_nxt;
  entry_t             rd_data_r;
  entry_t             mem [DEPTH];

  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_req_r;
  logic               out_upd_r;
  logic [FRAME_W-1:0] out_shown_r;
  logic [TICK_W-1:0]  out_tick_r;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic [IDX_W-1:0]   last_idx;
  logic [ECNT_W-1:0]  cnt_m1;
  logic [TICK_W-1:0]  len;
  logic [TICK_W-1:0]  tick_wrap;
  logic [TICK_W:0]    tick_p1;
  logic [TICK_W-1:0]  tick_adv;
  logic [ACC_W-1:0]   at_sum;
  logic               hit;
  logic [FRAME_W-1:0] sel_frame;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;

  assign cnt_m1 = entry_count_r - ECNT_W'(1);
  always_comb begin
    if (entry_count_r == '0) begin
      last_idx = '0;
    end else if (entry_count_r > ECNT_W'(DEPTH)) begin
      last_idx = IDX_W'(DEPTH - 1);
    end else begin
      last_idx = cnt_m1[IDX_W-1:0];
    end
  end

  assign len       = (total_ticks_r == '0) ? TICK_W'(1) : total_ticks_r;
  assign tick_wrap = (tick_r >= len) ? '0 : tick_r;
  assign tick_p1   = {1'b0, tick_r} + (TICK_W+1)'(1);
  assign tick_adv  = (tick_p1 >= {1'b0, len}) ? '0 : tick_p1[TICK_W-1:0];

  assign at_sum    = at_r + ACC_W'(rd_data_r.dur);
  assign hit       = (tick_r < {{(TICK_W-ACC_W){1'b0}}, at_sum}) || (rd_idx_r == last_idx);
  assign sel_frame = (rd_data_r.frame < frame_count_r) ? rd_data_r.frame : '0;

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    pending_nxt   = pending_r;
    displayed_nxt = displayed_r;
    dirty_nxt     = dirty_r;
    addr_nxt      = addr_r;
    at_nxt        = at_r;
    rd_vld_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OUT;
          case (in_operation)
            OP_LOAD: begin
            end
            OP_TICK: begin
              if (freeze_r) begin
                if (displayed_r != '0) begin
                  pending_nxt = '0;
                  dirty_nxt   = 1'b1;
                end
                tick_nxt = '0;
              end else begin
                tick_nxt  = tick_wrap;
                at_nxt    = '0;
                addr_nxt  = '0;
                state_nxt = S_WALK;
              end
            end
            OP_DONE: begin
              if (dirty_r) begin
                displayed_nxt = pending_r;
                dirty_nxt     = 1'b0;
              end
            end
            OP_RESTART: begin
              tick_nxt      = '0;
              pending_nxt   = FRAME_NONE;
              displayed_nxt = FRAME_NONE;
              dirty_nxt     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (addr_r != last_idx) begin
          addr_nxt = addr_r + IDX_W'(1);
        end
        rd_vld_nxt = !(rd_vld_r && hit);
        if (rd_vld_r) begin
          if (hit) begin
            if (sel_frame != displayed_r) begin
              pending_nxt = sel_frame;
              dirty_nxt   = 1'b1;
            end
            tick_nxt  = tick_adv;
            state_nxt = S_OUT;
          end else begin
            at_nxt = at_sum;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_r        <= '0;
      pending_r     <= FRAME_NONE;
      displayed_r   <= FRAME_NONE;
      dirty_r       <= 1'b1;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_count_r <= ECNT_W'(1);
      frame_count_r <= FRAME_W'(1);
      total_ticks_r <= '0;
      freeze_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      pending_r   <= pending_nxt;
      displayed_r <= displayed_nxt;
      dirty_r     <= dirty_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENTRY_COUNT: entry_count_r <= cfg_wdata[ECNT_W-1:0];
          REG_FRAME_COUNT: frame_count_r <= cfg_wdata[FRAME_W-1:0];
          REG_TOTAL_TICKS: total_ticks_r <= cfg_wdata[TICK_W-1:0];
          REG_FREEZE_MODE: freeze_r      <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    at_r     <= at_nxt;
    rd_idx_r <= addr_r;
    if (out_load) begin
      out_req_r   <= pending_r;
      out_upd_r   <= dirty_r;
      out_shown_r <= displayed_r;
      out_tick_r  <= tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_LOAD)) begin
      mem[in_entry_index] <= '{frame: in_entry_frame, dur: in_entry_duration};
    end
    rd_data_r <= mem[addr_r];
  end

  assign out_valid           = out_valid_r;
  assign out_requested_frame = out_req_r;
  assign out_upload_needed   = out_upd_r;
  assign out_shown_frame     = out_shown_r;
  assign out_tick_position   = out_tick_r;

  // A clean state always means the pending frame is the one on screen.
  a_clean_matches: assert property (@(posedge clk) disable iff (!rst_n)
    !dirty_r |-> (pending_r == displayed_r))
    else $error("clean flag set while pending and shown frames differ");

  // A new result only appears after the sequencer has finished an item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");

  // Walk data is only consumed while walking.
  a_walk_data: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_WALK))
    else $error("memory data marked valid outside the walk");

  // The walk never reads past the last entry in use.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (addr_r <= last_idx))
    else $error("timeline walk address beyond the last entry");

  // A tick without freeze enters the walk on the cycle after its transfer.
  a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_operation == OP_TICK) && !freeze_r) |=> (state_r == S_WALK))
    else $error("tick transfer did not start a timeline walk");

endmodule

// File: bench/frame_pick_checker.sv
`timescale 1ns / 1ps
// Checker for the animation timeline frame selector: mirrors timeline, registers and playback
// state, predicts one report per input transfer and compares it with each result transfer.
// Depends on atfs_pkg; instantiated by testbench beside the block.
module frame_pick_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [atfs_pkg::OP_W-1:0]      in_operation,
  input  logic [atfs_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [atfs_pkg::FRAME_W-1:0]   in_entry_frame,
  input  logic [atfs_pkg::DUR_W-1:0]     in_entry_duration,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [atfs_pkg::FRAME_W-1:0]   out_requested_frame,
  input  logic                           out_upload_needed,
  input  logic [atfs_pkg::FRAME_W-1:0]   out_shown_frame,
  input  logic [atfs_pkg::TICK_W-1:0]    out_tick_position,
  input  logic                           cfg_wr_en,
  input  logic [atfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atfs_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             reports_waiting
);
  import atfs_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] requested;
    logic               needed;
    logic [FRAME_W-1:0] shown;
    logic [TICK_W-1:0]  position;
  } frame_report_t;

  frame_report_t expected_reports[$];

  logic [ECNT_W-1:0]  entry_count;
  logic [FRAME_W-1:0] frame_count;
  logic [TICK_W-1:0]  total_ticks;
  logic               freeze_mode;

  logic [FRAME_W-1:0] slot_frame [DEPTH];
  logic [DUR_W-1:0]   slot_dur [DEPTH];
  logic [TICK_W-1:0]  tick_count;
  logic [FRAME_W-1:0] pending_frame;
  logic [FRAME_W-1:0] shown_frame;
  logic               dirty;

  // The slot whose cumulative duration first passes the tick supplies the frame; a tick past
  // the end falls back to the last slot in use.
  function automatic logic [FRAME_W-1:0] pick_frame(logic [TICK_W-1:0] tick);
    int n;
    logic [TICK_W-1:0] reach;
    logic [FRAME_W-1:0] hit;
    n = (entry_count == '0) ? 1 : ((entry_count > DEPTH) ? DEPTH : int'(entry_count));
    reach = '0;
    hit = slot_frame[n-1];
    for (int i = 0; i < n; i++) begin
      reach = reach + TICK_W'(slot_dur[i]);
      if (tick < reach) begin
        hit = slot_frame[i];
        break;
      end
    end
    return (hit < frame_count) ? hit : '0;
  endfunction

  function automatic frame_report_t apply_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                               logic [FRAME_W-1:0] fr, logic [DUR_W-1:0] du);
    logic [TICK_W-1:0] span;
    logic [FRAME_W-1:0] chosen;
    frame_report_t report;
    span = total_ticks;
    if (span == '0) span = TICK_W'(1);
    case (op)
      OP_LOAD: begin
        slot_frame[idx] = fr;
        slot_dur[idx] = du;
      end
      OP_TICK: begin
        if (freeze_mode) begin
          if (shown_frame != '0) begin
            pending_frame = '0;
            dirty = 1'b1;
          end
          tick_count = '0;
        end else begin
          if (tick_count >= span) tick_count = '0;
          chosen = pick_frame(tick_count);
          if (chosen != shown_frame) begin
            pending_frame = chosen;
            dirty = 1'b1;
          end
          tick_count = tick_count + TICK_W'(1);
          if (tick_count >= span) tick_count = '0;
        end
      end
      OP_DONE: begin
        if (dirty) begin
          shown_frame = pending_frame;
          dirty = 1'b0;
        end
      end
      OP_RESTART: begin
        tick_count = '0;
        pending_frame = FRAME_NONE;
        shown_frame = FRAME_NONE;
        dirty = 1'b1;
      end
      default: ;
    endcase
    report.requested = pending_frame;
    report.needed = dirty;
    report.shown = shown_frame;
    report.position = tick_count;
    return report;
  endfunction

  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (!rst_n) begin
      entry_count = 8'd1;
      frame_count = 16'd1;
      total_ticks = '0;
      freeze_mode = 1'b0;
      tick_count = '0;
      pending_frame = FRAME_NONE;
      shown_frame = FRAME_NONE;
      dirty = 1'b1;
      mismatches = 0;
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENTRY_COUNT: entry_count = cfg_wdata[ECNT_W-1:0];
          REG_FRAME_COUNT: frame_count = cfg_wdata[FRAME_W-1:0];
          REG_TOTAL_TICKS: total_ticks = cfg_wdata[TICK_W-1:0];
          REG_FREEZE_MODE: freeze_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(apply_item(in_operation, in_entry_index, in_entry_frame,
                                              in_entry_duration));
      if (out_valid && !out_stall) begin
        got.requested = out_requested_frame;
        got.needed = out_upload_needed;
        got.shown = out_shown_frame;
        got.position = out_tick_position;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transfer: frame %h upload %b shown %h tick %h",
                     $time, got.requested, got.needed, got.shown, got.position);
        end else begin
          want = expected_reports.pop_front();
          if (got.requested !== want.requested || got.needed !== want.needed ||
              got.shown !== want.shown || got.position !== want.position) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected frame %h upload %b shown %h tick %h", $time,
                       want.requested, want.needed, want.shown, want.position);
              $display("%0t:           actual frame %h upload %b shown %h tick %h", $time,
                       got.requested, got.needed, got.shown, got.position);
            end
          end
        end
      end
    end
    reports_waiting = expected_reports.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the frame selector testbench: clock, reset, register writes, stimulus and verdict.
// Depends on atfs_pkg, animation_timeline_frame_selector_top and frame_pick_checker.
module testbench;
  import atfs_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_FREEZE_MODE + 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation;
  logic [IDX_W-1:0]     in_entry_index;
  logic [FRAME_W-1:0]   in_entry_frame;
  logic [DUR_W-1:0]     in_entry_duration;
  logic                 out_valid;
  logic                 out_stall;
  logic [FRAME_W-1:0]   out_requested_frame;
  logic                 out_upload_needed;
  logic [FRAME_W-1:0]   out_shown_frame;
  logic [TICK_W-1:0]    out_tick_position;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int mismatches;
  int reports_waiting;
  int cycle_count = 0;
  int hold_requests = 0;
  bit tx_gaps = 1'b0;
  bit rx_quiet = 1'b0;
  logic [ECNT_W-1:0] cur_entry_count = 8'd1;
  bit [DEPTH-1:0] slot_loaded = '0;
  int op_total[4] = '{0, 0, 0, 0};
  int settings_used = 0;
  int random_items = 0;

  always #1 clk = ~clk;

  animation_timeline_frame_selector_top dut (.*);

  frame_pick_checker pick_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               reports_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches, and long hold-offs counted down here.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 20);
      end
    end
  end

  function automatic int slots_in_use(logic [ECNT_W-1:0] ec);
    return (ec == '0) ? 1 : ((ec > DEPTH) ? DEPTH : int'(ec));
  endfunction

  function automatic logic [FRAME_W-1:0] rand_frame();
    int r;
    r = $urandom_range(99);
    if (r < 70) return FRAME_W'($urandom_range(0, 15));
    else if (r < 80) return FRAME_NONE;
    else return FRAME_W'($urandom);
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    int r;
    r = $urandom_range(99);
    if (r < 60) return DUR_W'($urandom_range(0, 4));
    else if (r < 88) return DUR_W'($urandom_range(5, 40));
    else return DUR_W'($urandom);
  endfunction

  // Returns at the rising edge of the transfer; the next call drives at the falling edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [FRAME_W-1:0] fr, input logic [DUR_W-1:0] du);
    @(negedge clk);
    if (tx_gaps && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_index <= idx;
    in_entry_frame <= fr;
    in_entry_duration <= du;
    do @(posedge clk); while (in_stall);
    op_total[op]++;
    if (op == OP_LOAD) slot_loaded[idx] = 1'b1;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    send_item(op, IDX_W'($urandom), FRAME_W'($urandom), DUR_W'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_waiting != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [ECNT_W-1:0] ec, input logic [FRAME_W-1:0] fc,
                            input logic [TICK_W-1:0] tt, input logic fm);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_wdata <= CFG_W'(ec);
    @(negedge clk);
    cfg_index <= REG_FRAME_COUNT;
    cfg_wdata <= CFG_W'(fc);
    @(negedge clk);
    cfg_index <= REG_TOTAL_TICKS;
    cfg_wdata <= CFG_W'(tt);
    @(negedge clk);
    cfg_index <= REG_FREEZE_MODE;
    cfg_wdata <= CFG_W'(fm);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_entry_count = ec;
    settings_used++;
  endtask

  // Every slot a tick may read is loaded first; some loaded slots get fresh content.
  task automatic fill_timeline();
    int n;
    n = slots_in_use(cur_entry_count);
    for (int i = 0; i < n; i++) begin
      if (!slot_loaded[i] || $urandom_range(99) < 30) begin
        send_item(OP_LOAD, IDX_W'(i), rand_frame(), rand_duration());
        random_items++;
      end
    end
  endtask

  initial begin
    int r;
    int body;
    int phase_no;
    bit quiet;
    logic [ECNT_W-1:0] ec;
    logic [FRAME_W-1:0] fc;
    logic [TICK_W-1:0] tt;
    logic fm;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    in_entry_index = '0;
    in_entry_frame = '0;
    in_entry_duration = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_ENTRY_COUNT;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults: upload-done while dirty and while clean, field extremes, clipping.
    send_op(OP_DONE);
    send_op(OP_DONE);
    send_item(OP_LOAD, '0, 16'hffff, 16'hffff);
    send_item(OP_LOAD, IDX_W'(DEPTH - 1), 16'h0000, 16'h0000);
    send_op(OP_TICK);
    send_op(OP_DONE);
    send_op(OP_TICK);
    send_op(OP_RESTART);
    drain();

    // A write past the last register must leave everything alone.
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PAST_END;
    cfg_wdata <= '1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;

    // Entry count and frame count of zero, short animation that wraps.
    set_config(8'd0, 16'd0, 32'd3, 1'b0);
    repeat (4) send_op(OP_TICK);
    drain();

    // Three slots, one frame out of range, ticks running past the end of the timeline.
    set_config(8'd3, 16'd100, 32'd20, 1'b0);
    send_item(OP_LOAD, 7'd1, 16'd50, 16'd2);
    send_item(OP_LOAD, 7'd2, 16'd200, 16'd1);
    send_item(OP_LOAD, 7'd0, 16'd7, 16'd3);
    repeat (7) send_op(OP_TICK);
    drain();

    // Freeze mode requests frame zero until it is shown.
    set_config(8'd3, 16'd100, 32'd20, 1'b1);
    send_op(OP_TICK);
    send_op(OP_DONE);
    send_op(OP_TICK);

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      case (phase_no)
        0: begin
          ec = 8'd128; fc = 16'd16; tt = 32'd600; fm = 1'b0;
        end
        1: begin
          ec = 8'd255; fc = 16'hffff; tt = 32'hffffffff; fm = 1'b0;
        end
        default: begin
          r = $urandom_range(99);
          if (r < 5) ec = 8'd0;
          else if (r < 55) ec = ECNT_W'($urandom_range(1, 8));
          else if (r < 75) ec = ECNT_W'($urandom_range(9, 40));
          else if (r < 85) ec = ECNT_W'($urandom_range(41, 127));
          else if (r < 95) ec = 8'd128;
          else ec = ECNT_W'($urandom_range(129, 255));
          r = $urandom_range(99);
          if (r < 10) fc = 16'd0;
          else if (r < 20) fc = 16'hffff;
          else if (r < 80) fc = FRAME_W'($urandom_range(1, 16));
          else fc = FRAME_W'($urandom);
          r = $urandom_range(99);
          if (r < 15) tt = 32'd0;
          else if (r < 25) tt = 32'd1;
          else if (r < 65) tt = $urandom_range(2, 60);
          else if (r < 80) tt = $urandom_range(61, 2000);
          else if (r < 90) tt = 32'hffffffff;
          else tt = $urandom;
          fm = ($urandom_range(99) < 15);
        end
      endcase
      quiet = (phase_no % 6 == 1);
      tx_gaps = !quiet;
      rx_quiet = quiet;
      set_config(ec, fc, tt, fm);
      fill_timeline();
      body = quiet ? 150 : $urandom_range(15, 70);
      for (int k = 0; k < body; k++) begin
        if (k == 5 && phase_no % 7 == 3) hold_requests++;
        r = $urandom_range(99);
        if (r < 45) begin
          send_op(OP_TICK);
        end else if (r < 70) begin
          send_op(OP_DONE);
        end else if (r < 90) begin
          if ($urandom_range(99) < 70)
            send_item(OP_LOAD, IDX_W'($urandom_range(0, slots_in_use(cur_entry_count) - 1)),
                      rand_frame(), rand_duration());
          else
            send_item(OP_LOAD, IDX_W'($urandom_range(0, DEPTH - 1)), rand_frame(),
                      rand_duration());
        end else begin
          send_op(OP_RESTART);
        end
        random_items++;
      end
      phase_no++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d loads, %0d ticks, %0d upload-done and %0d restart transfers",
             op_total[OP_LOAD], op_total[OP_TICK], op_total[OP_DONE], op_total[OP_RESTART]);
    $display("over %0d register settings with %0d result mismatches", settings_used,
             mismatches);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
